// ----- design/skrt_pkg.sv -----
// ----------------------------------------------------------------------------
// skrt_pkg
// Types and codes shared by the sorted result table and its table engine.
// ----------------------------------------------------------------------------
package skrt_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_NODE_ID = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_IS_TAG  = 8'd1;

   // item functions
   localparam logic [1:0] FUNC_STORE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [2:0] QUALITY_UNSYNCED = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  tag_id;
      logic [7:0]  anchor_id;
      logic [1:0]  range_status;
      logic [31:0] distance_mm;
      logic [2:0]  time_quality;
      logic [63:0] completed_time_us;
      logic [2:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        changed;
      logic [3:0]  entry_count;
      logic [2:0]  latest_quality;
      logic        entry_valid;
      logic [7:0]  entry_anchor_id;
      logic [7:0]  entry_tag_id;
      logic [1:0]  entry_status;
      logic [31:0] entry_distance_mm;
      logic [2:0]  entry_time_quality;
      logic [63:0] entry_time_us;
   } rsp_type;

   // one stored table row
   typedef struct packed {
      logic [7:0]  anchor_id;
      logic [7:0]  tag_id;
      logic [1:0]  status;
      logic [31:0] distance_mm;
      logic [2:0]  time_quality;
      logic [63:0] time_us;
   } entry_type;

   typedef struct packed {
      logic [7:0] local_node_id;
      logic       local_is_tag;
   } cfg_type;

endpackage

// ----- design/skrt_engine.sv -----
// ----------------------------------------------------------------------------
// skrt_engine
// Table memory and the sequencer that searches, shifts and writes it one row
// per step through a single read port and a single write port.
// ----------------------------------------------------------------------------
module skrt_engine #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  skrt_pkg::req_type req,
   input  skrt_pkg::cfg_type cfg,
   output logic             busy,
   output logic             rsp_valid,
   output skrt_pkg::rsp_type rsp
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (CW > 3) ? CW : 3;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_SRCH     = 4'd2;
   localparam logic [3:0] ST_SRCH_CHK = 4'd3;
   localparam logic [3:0] ST_SHIFT_RD = 4'd4;
   localparam logic [3:0] ST_SHIFT_WR = 4'd5;
   localparam logic [3:0] ST_WRITE    = 4'd6;
   localparam logic [3:0] ST_READ_WT  = 4'd7;

   skrt_pkg::entry_type mem [MAX_ENTRIES];
   skrt_pkg::entry_type rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   skrt_pkg::entry_type wr_data;

   logic [3:0]          state_ff, state_in;
   skrt_pkg::req_type   req_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [2:0]          qual_ff, qual_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                insert_ff, insert_in;
   logic                rsp_valid_ff, rsp_valid_in;
   skrt_pkg::rsp_type   rsp_ff, rsp_in;

   skrt_pkg::entry_type new_entry;
   logic [IW-1:0]       ridx_ext;
   logic                ridx_ok;
   logic                own_store;

   assign new_entry = '{anchor_id:    req_ff.anchor_id,
                        tag_id:       req_ff.tag_id,
                        status:       req_ff.range_status,
                        distance_mm:  req_ff.distance_mm,
                        time_quality: req_ff.time_quality,
                        time_us:      req_ff.completed_time_us};

   assign ridx_ext  = IW'(req_ff.read_index);
   assign ridx_ok   = ridx_ext < IW'(count_ff);
   assign own_store = cfg.local_is_tag && (req_ff.tag_id == cfg.local_node_id);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      qual_in      = qual_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      insert_in    = insert_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = new_entry;

      // default answer: status only, empty entry fields
      rsp_in                = '0;
      rsp_in.entry_count    = 4'(count_ff);
      rsp_in.latest_quality = qual_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (req_ff.func)
               skrt_pkg::FUNC_STORE: begin
                  if (own_store) begin
                     pos_in   = '0;
                     state_in = ST_SRCH;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               skrt_pkg::FUNC_CLEAR: begin
                  count_in              = '0;
                  qual_in               = skrt_pkg::QUALITY_UNSYNCED;
                  rsp_in.changed        = 1'b1;
                  rsp_in.entry_count    = '0;
                  rsp_in.latest_quality = skrt_pkg::QUALITY_UNSYNCED;
                  rsp_valid_in          = 1'b1;
                  state_in              = ST_IDLE;
               end
               skrt_pkg::FUNC_READ: begin
                  if (ridx_ok) begin
                     rd_addr  = ridx_ext[AW-1:0];
                     state_in = ST_READ_WT;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_SRCH: begin
            if (pos_ff == count_ff) begin
               // ran past every key: append, or drop when full
               if (count_ff < MAX_COUNT) begin
                  insert_in = 1'b1;
                  idx_in    = count_ff[AW-1:0];
                  state_in  = ST_SHIFT_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rd_addr  = pos_ff[AW-1:0];
               state_in = ST_SRCH_CHK;
            end
         end
         ST_SRCH_CHK: begin
            if (rd_data_ff.anchor_id < req_ff.anchor_id) begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_SRCH;
            end else if (rd_data_ff.anchor_id == req_ff.anchor_id) begin
               insert_in = 1'b0;
               state_in  = ST_WRITE;
            end else if (count_ff < MAX_COUNT) begin
               insert_in = 1'b1;
               idx_in    = count_ff[AW-1:0];
               state_in  = ST_SHIFT_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SHIFT_RD: begin
            if (CW'(idx_ff) == pos_ff) begin
               state_in = ST_WRITE;
            end else begin
               rd_addr  = idx_ff - 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            qual_in = req_ff.time_quality;
            if (insert_ff) begin
               count_in = count_ff + 1'b1;
            end
            rsp_in.changed        = 1'b1;
            rsp_in.entry_count    = 4'(count_in);
            rsp_in.latest_quality = req_ff.time_quality;
            rsp_valid_in          = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_READ_WT: begin
            rsp_in.entry_valid        = 1'b1;
            rsp_in.entry_anchor_id    = rd_data_ff.anchor_id;
            rsp_in.entry_tag_id       = rd_data_ff.tag_id;
            rsp_in.entry_status       = rd_data_ff.status;
            rsp_in.entry_distance_mm  = rd_data_ff.distance_mm;
            rsp_in.entry_time_quality = rd_data_ff.time_quality;
            rsp_in.entry_time_us      = rd_data_ff.time_us;
            rsp_valid_in              = 1'b1;
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         qual_ff      <= skrt_pkg::QUALITY_UNSYNCED;
         insert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         qual_ff      <= qual_in;
         insert_ff    <= insert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- design/sorted_keyed_result_table.sv -----
// ----------------------------------------------------------------------------
// sorted_keyed_result_table
// Ranging result table kept in ascending anchor order, with config registers.
// ----------------------------------------------------------------------------
// Timing: a store walks the keys below it and moves every row behind its slot,
// one row per step through the single-port table; a drop on full ends sooner.
// Throughput: one beat at a time; start is taken again the cycle busy drops.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset: empty table, latest quality unsynchronized, node id 0, tag mode on.
// ----------------------------------------------------------------------------
module sorted_keyed_result_table #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  skrt_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output skrt_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [skrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skrt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   skrt_pkg::cfg_type cfg_ff, cfg_in;
   logic              accept;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            skrt_pkg::CSR_LOCAL_NODE_ID: cfg_in.local_node_id = csr_wdata[7:0];
            skrt_pkg::CSR_LOCAL_IS_TAG:  cfg_in.local_is_tag  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_node_id <= 8'd0;
         cfg_ff.local_is_tag  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   skrt_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg_ff),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted ranging result table. A queue-fed driver
// issues store, clear, read and unused-code commands and register writes. Each accepted
// command goes through a local model of the table, which gives the answer that
// is due. A monitor checks every result strobe, field by field, against the
// oldest answer due.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH = 8;
   localparam logic [1:0] FUNC_NONE = 2'd3;   // unused code, block ignores it

   typedef enum {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type       kind;
      skrt_pkg::req_type item;
      logic [7:0]        idx;
      logic [7:0]        data;
      int                gap;
   } work_op_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   skrt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   skrt_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [skrt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [skrt_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   work_op_type       work_list[$];
   skrt_pkg::rsp_type answers_due[$];

   // local copy of the table and registers
   skrt_pkg::entry_type rows[DEPTH];
   int                  row_count = 0;
   logic [2:0]          last_q = skrt_pkg::QUALITY_UNSYNCED;
   logic [7:0]          cfg_node_id = 8'd0;
   logic                cfg_is_tag = 1'b1;

   int fault_count = 0;
   int n_items = 0, n_checked = 0;
   int n_taken = 0, n_dropped = 0, n_rejected = 0, n_hits = 0;
   int hold_cnt = 0, quiet = 0;

   sorted_keyed_result_table #(.MAX_ENTRIES(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_fault(string msg);
      fault_count++;
      $display("tb_top: mismatch: %s", msg);
   endtask

   // applies one command to the local table, returns the answer it gives
   function automatic skrt_pkg::rsp_type table_apply(skrt_pkg::req_type it);
      skrt_pkg::rsp_type   r;
      skrt_pkg::entry_type e;
      int                  pos;
      r = '0;
      e.anchor_id    = it.anchor_id;
      e.tag_id       = it.tag_id;
      e.status       = it.range_status;
      e.distance_mm  = it.distance_mm;
      e.time_quality = it.time_quality;
      e.time_us      = it.completed_time_us;
      case (it.func)
         skrt_pkg::FUNC_STORE: begin
            if (cfg_is_tag && it.tag_id == cfg_node_id) begin
               pos = 0;
               while (pos < row_count && rows[pos].anchor_id < it.anchor_id) pos++;
               if (pos < row_count && rows[pos].anchor_id == it.anchor_id) begin
                  rows[pos] = e;
                  last_q = it.time_quality;
                  r.changed = 1'b1;
                  n_taken++;
               end else if (row_count < DEPTH) begin
                  for (int i = row_count; i > pos; i--) rows[i] = rows[i-1];
                  rows[pos] = e;
                  row_count++;
                  last_q = it.time_quality;
                  r.changed = 1'b1;
                  n_taken++;
               end else begin
                  n_dropped++;
               end
            end else begin
               n_rejected++;
            end
         end
         skrt_pkg::FUNC_CLEAR: begin
            foreach (rows[i]) rows[i] = '0;
            row_count = 0;
            last_q = skrt_pkg::QUALITY_UNSYNCED;
            r.changed = 1'b1;
         end
         skrt_pkg::FUNC_READ: begin
            if (int'(it.read_index) < row_count) begin
               r.entry_valid        = 1'b1;
               r.entry_anchor_id    = rows[it.read_index].anchor_id;
               r.entry_tag_id       = rows[it.read_index].tag_id;
               r.entry_status       = rows[it.read_index].status;
               r.entry_distance_mm  = rows[it.read_index].distance_mm;
               r.entry_time_quality = rows[it.read_index].time_quality;
               r.entry_time_us      = rows[it.read_index].time_us;
               n_hits++;
            end
         end
         default: ;
      endcase
      r.entry_count    = 4'(row_count);
      r.latest_quality = last_q;
      return r;
   endfunction

   // driver: one command or register write in flight at a time
   always @(posedge clock) begin : drive
      logic        start_n;
      logic        csr_n;
      work_op_type op;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         hold_cnt = 0;
         quiet    = 0;
      end else begin
         start_n = start;
         csr_n   = csr_valid;
         if (start && !busy) begin
            answers_due.push_back(table_apply(req_data));
            n_items++;
            start_n = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               skrt_pkg::CSR_LOCAL_NODE_ID: cfg_node_id = csr_wdata[7:0];
               skrt_pkg::CSR_LOCAL_IS_TAG:  cfg_is_tag  = csr_wdata[0];
               default: ;
            endcase
            csr_n = 1'b0;
         end
         if (answers_due.size() == 0 && !busy) quiet++;
         else quiet = 0;
         if (!start_n && !csr_n && work_list.size() > 0) begin
            op = work_list[0];
            case (op.kind)
               OP_ITEM: begin
                  if (hold_cnt < op.gap) begin
                     hold_cnt++;
                  end else begin
                     req_data <= op.item;
                     start_n  = 1'b1;
                     hold_cnt = 0;
                     void'(work_list.pop_front());
                  end
               end
               OP_CSR: begin
                  // registers only change with the block idle
                  if (quiet >= 3) begin
                     csr_index <= op.idx;
                     csr_wdata <= op.data;
                     csr_n = 1'b1;
                     void'(work_list.pop_front());
                  end
               end
               OP_DRAIN: begin
                  if (quiet >= 1) void'(work_list.pop_front());
               end
               default: ;
            endcase
         end
         start     <= start_n;
         csr_valid <= csr_n;
      end
   end

   // monitor: every strobe must match the oldest answer due
   always @(posedge clock) begin : observe
      skrt_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_fault($sformatf("result with nothing due: %h", rsp_data));
         end else begin
            want = answers_due.pop_front();
            n_checked++;
            if (rsp_data.changed !== want.changed)
               report_fault($sformatf("changed got %0h want %0h",
                  rsp_data.changed, want.changed));
            if (rsp_data.entry_count !== want.entry_count)
               report_fault($sformatf("entry_count got %0h want %0h",
                  rsp_data.entry_count, want.entry_count));
            if (rsp_data.latest_quality !== want.latest_quality)
               report_fault($sformatf("latest_quality got %0h want %0h",
                  rsp_data.latest_quality, want.latest_quality));
            if (rsp_data.entry_valid !== want.entry_valid)
               report_fault($sformatf("entry_valid got %0h want %0h",
                  rsp_data.entry_valid, want.entry_valid));
            if (rsp_data.entry_anchor_id !== want.entry_anchor_id)
               report_fault($sformatf("entry_anchor_id got %0h want %0h",
                  rsp_data.entry_anchor_id, want.entry_anchor_id));
            if (rsp_data.entry_tag_id !== want.entry_tag_id)
               report_fault($sformatf("entry_tag_id got %0h want %0h",
                  rsp_data.entry_tag_id, want.entry_tag_id));
            if (rsp_data.entry_status !== want.entry_status)
               report_fault($sformatf("entry_status got %0h want %0h",
                  rsp_data.entry_status, want.entry_status));
            if (rsp_data.entry_distance_mm !== want.entry_distance_mm)
               report_fault($sformatf("entry_distance_mm got %0h want %0h",
                  rsp_data.entry_distance_mm, want.entry_distance_mm));
            if (rsp_data.entry_time_quality !== want.entry_time_quality)
               report_fault($sformatf("entry_time_quality got %0h want %0h",
                  rsp_data.entry_time_quality, want.entry_time_quality));
            if (rsp_data.entry_time_us !== want.entry_time_us)
               report_fault($sformatf("entry_time_us got %0h want %0h",
                  rsp_data.entry_time_us, want.entry_time_us));
         end
      end
   end

   task automatic push_item(skrt_pkg::req_type it, int gap);
      work_op_type op;
      op.kind = OP_ITEM;
      op.item = it;
      op.idx  = '0;
      op.data = '0;
      op.gap  = gap;
      work_list.push_back(op);
   endtask

   task automatic push_csr(logic [7:0] idx, logic [7:0] data);
      work_op_type op;
      op.kind = OP_CSR;
      op.item = '0;
      op.idx  = idx;
      op.data = data;
      op.gap  = 0;
      work_list.push_back(op);
   endtask

   task automatic push_drain();
      work_op_type op;
      op.kind = OP_DRAIN;
      op.item = '0;
      op.idx  = '0;
      op.data = '0;
      op.gap  = 0;
      work_list.push_back(op);
   endtask

   function automatic skrt_pkg::req_type store_req(logic [7:0] tag, logic [7:0] anchor,
                                                   logic [1:0] st, logic [31:0] mm,
                                                   logic [2:0] q, logic [63:0] tus);
      skrt_pkg::req_type it;
      it = '0;
      it.func              = skrt_pkg::FUNC_STORE;
      it.tag_id            = tag;
      it.anchor_id         = anchor;
      it.range_status      = st;
      it.distance_mm       = mm;
      it.time_quality      = q;
      it.completed_time_us = tus;
      return it;
   endfunction

   function automatic skrt_pkg::req_type read_req(logic [2:0] idx);
      skrt_pkg::req_type it;
      it = '0;
      it.func       = skrt_pkg::FUNC_READ;
      it.read_index = idx;
      return it;
   endfunction

   // mostly stores for this node over a narrow anchor set, so the table fills
   function automatic skrt_pkg::req_type random_req(logic [7:0] node);
      skrt_pkg::req_type it;
      int                pick;
      it.tag_id            = 8'($urandom);
      it.anchor_id         = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 11) * 23);
      it.range_status      = 2'($urandom);
      it.distance_mm       = $urandom;
      it.time_quality      = 3'($urandom);
      it.completed_time_us = {$urandom, $urandom};
      it.read_index        = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         it.func = skrt_pkg::FUNC_STORE;
         if ($urandom_range(0, 9) != 0) it.tag_id = node;
      end else if (pick < 88) it.func = skrt_pkg::FUNC_READ;
      else if (pick < 94)     it.func = skrt_pkg::FUNC_CLEAR;
      else if (pick < 97)     it.func = FUNC_NONE;
      else                    it.func = skrt_pkg::FUNC_STORE;
      return it;
   endfunction

   initial begin : stimulus
      skrt_pkg::req_type it;
      logic [7:0]        node;
      logic              is_tag;
      bit                bursty;
      int                burst_len;

      // directed part, reset registers: node 0, tag mode on
      push_item(read_req(3'd0), 0);
      push_item(store_req(8'd0, 8'd128, 2'd0, 32'd0, 3'd0, 64'd0), 1);
      push_item(store_req(8'd0, 8'd255, 2'd3, '1, 3'd7, '1), 0);
      push_item(store_req(8'd0, 8'd0, 2'd1, 32'h1234_5678, 3'd5, 64'h1), 2);
      push_item(store_req(8'd0, 8'd128, 2'd2, 32'h8000_0000, 3'd6,
                          64'h8000_0000_0000_0000), 0);
      push_item(store_req(8'd1, 8'd50, 2'd0, 32'd99, 3'd1, 64'd7), 3);   // other tag
      it = store_req(8'd0, 8'd77, 2'd1, 32'd5, 3'd2, 64'd9);
      it.func = FUNC_NONE;
      push_item(it, 0);
      push_item(store_req(8'd0, 8'd10, 2'd0, 32'd1000, 3'd0, 64'd100), 0);
      push_item(store_req(8'd0, 8'd20, 2'd1, 32'd2000, 3'd1, 64'd200), 1);
      push_item(store_req(8'd0, 8'd30, 2'd2, 32'd3000, 3'd2, 64'd300), 0);
      push_item(store_req(8'd0, 8'd40, 2'd3, 32'd4000, 3'd3, 64'd400), 2);
      push_item(store_req(8'd0, 8'd50, 2'd0, 32'd5000, 3'd4, 64'd500), 0);
      push_item(store_req(8'd0, 8'd60, 2'd1, 32'd6000, 3'd1, 64'd600), 0);  // full: dropped
      push_item(store_req(8'd0, 8'd30, 2'd3, 32'd3333, 3'd7, 64'd333), 1);  // full: overwrite
      for (int i = 0; i < DEPTH; i++) push_item(read_req(3'(i)), $urandom_range(0, 3));
      it = '0;
      it.func = skrt_pkg::FUNC_CLEAR;
      push_item(it, 0);
      push_item(read_req(3'd0), 0);

      // random part, one register setting per phase
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       begin node = 8'd255; is_tag = 1'b1; end
            1:       begin node = 8'd0;   is_tag = 1'b1; end
            2:       begin node = 8'($urandom); is_tag = 1'b0; end
            default: begin node = 8'($urandom); is_tag = 1'b1; end
         endcase
         push_drain();
         push_csr(skrt_pkg::CSR_LOCAL_NODE_ID, node);
         push_csr(skrt_pkg::CSR_LOCAL_IS_TAG, {7'($urandom), is_tag});
         bursty    = 1'b0;
         burst_len = 0;
         for (int n = 0; n < 135; n++) begin
            if (burst_len == 0) begin
               bursty    = ($urandom_range(0, 2) == 0);
               burst_len = $urandom_range(5, 30);
            end
            burst_len--;
            if ($urandom_range(0, 49) == 0) push_drain();
            push_item(random_req(node), bursty ? 0 : $urandom_range(0, 3));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (work_list.size() > 0 || start || csr_valid || answers_due.size() > 0);
      repeat (4 * DEPTH + 8) @(negedge clock);

      while (answers_due.size() > 0) begin
         it = '0;
         report_fault($sformatf("answer never came: %h", answers_due.pop_front()));
      end
      $display("tb_top: %0d commands, %0d results checked", n_items, n_checked);
      $display("tb_top: stores taken %0d, dropped on full %0d, rejected %0d, reads hit %0d",
               n_taken, n_dropped, n_rejected, n_hits);
      if (fault_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
